// ===== hdl/hptc_pkg.sv =====
`timescale 1ns / 1ps

package hptc_pkg;

  localparam int NUM_CAL   = 8;
  localparam int CAL_IDX_W = 3;

  typedef enum logic [CAL_IDX_W-1:0] {
    CAL_T1_T2    = 3'd0,
    CAL_T3_P1    = 3'd1,
    CAL_P2_P3    = 3'd2,
    CAL_P4_P5    = 3'd3,
    CAL_P6_P7    = 3'd4,
    CAL_P8_P9    = 3'd5,
    CAL_H1_H3_H2 = 3'd6,
    CAL_H4_H5_H6 = 3'd7
  } cal_idx_t;

  // Quotient pipeline of the pressure path.
  localparam int DIV_STEPS = 35;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int NUM_W     = 80;
  localparam int DEN_W     = 42;
  localparam int QUO_W     = DIV_STEPS + 1;

  localparam int PRE_LAT   = 10;
  localparam int POST_LAT  = 3;
  localparam int PIPE_LAT  = PRE_LAT + DIV_LAT + POST_LAT;

  typedef struct packed {
    logic neg;
    logic dz;
  } side_t;

endpackage

// ===== hdl/hptc_div.sv =====
`timescale 1ns / 1ps

module hptc_div import hptc_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0]     rem_r [0:DIV_STEPS-1];
  logic [DEN_W-1:0]     den_r [0:DIV_STEPS-1];
  logic [DIV_STEPS-1:0] quo_r [0:DIV_STEPS];
  logic                 sat_r [0:DIV_STEPS];

  // The quotient saturates when it would reach 2^DIV_STEPS.
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    quo_r[0] <= '0;
    sat_r[0] <= (num >= (NUM_W'(den) << DIV_STEPS));
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [NUM_W-1:0] sub_w;
    logic             ge_w;

    always_comb begin
      sub_w = NUM_W'(den_r[i]) << (DIV_STEPS - 1 - i);
      ge_w  = (rem_r[i] >= sub_w);
    end

    always_ff @(posedge clk) begin
      quo_r[i+1] <= {quo_r[i][DIV_STEPS-2:0], ge_w};
      sat_r[i+1] <= sat_r[i];
    end

    if (i < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[i+1] <= ge_w ? (rem_r[i] - sub_w) : rem_r[i];
        den_r[i+1] <= den_r[i];
      end
    end
  end

  assign quo = sat_r[DIV_STEPS] ? (QUO_W'(1) << DIV_STEPS) : QUO_W'(quo_r[DIV_STEPS]);

endmodule

// ===== hdl/humidity_pressure_temp_compensation.sv =====
`timescale 1ns / 1ps

// Compensates one raw temperature, pressure and humidity reading per clock
// cycle. A reading is taken whenever start is high (busy stays low), and its
// result appears for exactly one cycle with out_valid high; the receiver
// cannot stall it. The latency is set by the pressure quotient, which is
// resolved one bit per pipeline stage over 35 stages plus a saturation check.
// The user must write calibration words through the cfg channel only while no
// reading is in flight; the block itself does not enforce this.

module humidity_pressure_temp_compensation import hptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [19:0]          in_raw_temp,
  input  logic [19:0]          in_raw_press,
  input  logic [15:0]          in_raw_humid,
  output logic                 out_valid,
  output logic signed [14:0]   out_temp_centi,
  output logic [24:0]          out_press_q8,
  output logic [16:0]          out_humid_q10,
  output logic                 out_press_invalid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAL_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int TEMP_DLY = PIPE_LAT - 5;
  localparam int HUM_DLY  = PIPE_LAT - 13;
  localparam int SIDE_DLY = DIV_LAT + 2;

  localparam logic signed [18:0] TEMP_LO   = -19'sd4000;
  localparam logic signed [18:0] TEMP_HI   = 19'sd8500;
  localparam logic signed [32:0] PRESS_MAX = 33'sd33554431;
  localparam logic signed [33:0] HUM_MAX   = 34'sd419430400;

  logic [31:0] cal_r [0:NUM_CAL-1];

  logic signed [16:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic signed [8:0]  h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CAL; i++) begin
        cal_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      cal_r[cfg_index] <= cfg_data;
    end
  end

  assign t1 = $signed({1'b0, cal_r[CAL_T1_T2][15:0]});
  assign t2 = $signed(cal_r[CAL_T1_T2][31:16]);
  assign t3 = $signed(cal_r[CAL_T3_P1][15:0]);
  assign p1 = $signed({1'b0, cal_r[CAL_T3_P1][31:16]});
  assign p2 = $signed(cal_r[CAL_P2_P3][15:0]);
  assign p3 = $signed(cal_r[CAL_P2_P3][31:16]);
  assign p4 = $signed(cal_r[CAL_P4_P5][15:0]);
  assign p5 = $signed(cal_r[CAL_P4_P5][31:16]);
  assign p6 = $signed(cal_r[CAL_P6_P7][15:0]);
  assign p7 = $signed(cal_r[CAL_P6_P7][31:16]);
  assign p8 = $signed(cal_r[CAL_P8_P9][15:0]);
  assign p9 = $signed(cal_r[CAL_P8_P9][31:16]);
  assign h1 = $signed({1'b0, cal_r[CAL_H1_H3_H2][7:0]});
  assign h3 = $signed({1'b0, cal_r[CAL_H1_H3_H2][15:8]});
  assign h2 = $signed(cal_r[CAL_H1_H3_H2][31:16]);
  assign h4 = $signed(cal_r[CAL_H4_H5_H6][11:0]);
  assign h5 = $signed(cal_r[CAL_H4_H5_H6][23:12]);
  assign h6 = $signed(cal_r[CAL_H4_H5_H6][31:24]);

  logic        vld_r [0:PIPE_LAT-2];
  logic        out_valid_r;
  logic [19:0] p_dly_r [0:5];
  logic [15:0] h_dly_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT - 1; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i < PIPE_LAT - 1; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[PIPE_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    p_dly_r[0] <= in_raw_press;
    for (int i = 1; i < 6; i++) begin
      p_dly_r[i] <= p_dly_r[i-1];
    end
    h_dly_r[0] <= in_raw_humid;
    for (int i = 1; i < 4; i++) begin
      h_dly_r[i] <= h_dly_r[i-1];
    end
  end

  // Stage 1
  logic signed [18:0] s1_diff;
  logic signed [16:0] s1_dt;
  logic signed [34:0] s1_ta_nxt, s1_ta_r;
  logic signed [33:0] s1_dd_nxt, s1_dd_r;

  always_comb begin
    s1_diff   = 19'($signed({1'b0, in_raw_temp[19:3]})) - 19'($signed({t1, 1'b0}));
    s1_dt     = $signed({1'b0, in_raw_temp[19:4]}) - t1;
    s1_ta_nxt = s1_diff * t2;
    s1_dd_nxt = s1_dt * s1_dt;
  end

  // Stage 2
  logic signed [21:0] s2_ddh;
  logic signed [22:0] s2_a_nxt, s2_a_r;
  logic signed [37:0] s2_bm_nxt, s2_bm_r;

  always_comb begin
    s2_a_nxt  = 23'(s1_ta_r >>> 11);
    s2_ddh    = $signed({1'b0, s1_dd_r[32:12]});
    s2_bm_nxt = s2_ddh * t3;
  end

  // Stage 3
  logic signed [23:0] s3_tf_nxt, s3_tf_r;

  assign s3_tf_nxt = 24'(s2_a_r) + 24'(s2_bm_r >>> 14);

  // Stage 4
  logic signed [26:0] s4_tm;
  logic signed [18:0] s4_tsh;
  logic signed [24:0] s4_hv;
  logic signed [14:0] s4_temp_nxt, s4_temp_r;
  logic signed [24:0] s4_v1_nxt, s4_v1_r;
  logic signed [49:0] s4_v1sq_nxt, s4_v1sq_r;
  logic signed [40:0] s4_v1p2_nxt, s4_v1p2_r;
  logic signed [36:0] s4_h5hv_nxt, s4_h5hv_r;
  logic signed [32:0] s4_hvh6_nxt, s4_hvh6_r;
  logic signed [33:0] s4_hvh3_nxt, s4_hvh3_r;

  always_comb begin
    s4_tm  = 27'(s3_tf_r) * 27'sd5 + 27'sd128;
    s4_tsh = 19'(s4_tm >>> 8);
    if (s4_tsh < TEMP_LO) begin
      s4_temp_nxt = 15'(TEMP_LO);
    end else if (s4_tsh > TEMP_HI) begin
      s4_temp_nxt = 15'(TEMP_HI);
    end else begin
      s4_temp_nxt = 15'(s4_tsh);
    end
    s4_v1_nxt   = 25'(s3_tf_r) - 25'sd128000;
    s4_hv       = 25'(s3_tf_r) - 25'sd76800;
    s4_v1sq_nxt = s4_v1_nxt * s4_v1_nxt;
    s4_v1p2_nxt = s4_v1_nxt * p2;
    s4_h5hv_nxt = s4_hv * h5;
    s4_hvh6_nxt = s4_hv * h6;
    s4_hvh3_nxt = s4_hv * h3;
  end

  // Stage 5
  logic signed [30:0] s5_hx1;
  logic signed [31:0] s5_h4s;
  logic signed [39:0] s5_hsum;
  logic signed [65:0] s5_q6_nxt, s5_q6_r, s5_q3_nxt, s5_q3_r;
  logic signed [40:0] s5_v1p5_nxt, s5_v1p5_r, s5_v1p2_r;
  logic signed [24:0] s5_ha_nxt, s5_ha_r;
  logic signed [23:0] s5_hb1_nxt, s5_hb1_r;
  logic signed [24:0] s5_hb2_nxt, s5_hb2_r;

  always_comb begin
    s5_q6_nxt   = s4_v1sq_r * p6;
    s5_q3_nxt   = s4_v1sq_r * p3;
    s5_v1p5_nxt = s4_v1_r * p5;
    s5_hx1      = $signed({1'b0, h_dly_r[3], 14'd0});
    s5_h4s      = $signed({h4, 20'd0});
    s5_hsum     = 40'(s5_hx1) - 40'(s5_h4s) - 40'(s4_h5hv_r) + 40'sd16384;
    s5_ha_nxt   = 25'(s5_hsum >>> 15);
    s5_hb1_nxt  = 24'(s4_hvh6_r >>> 10);
    s5_hb2_nxt  = 25'(s4_hvh3_r >>> 11) + 25'sd32768;
  end

  // Stage 6
  logic signed [67:0] s6_v2_nxt, s6_v2_r;
  logic signed [58:0] s6_aa_nxt, s6_aa_r;
  logic signed [48:0] s6_hb_nxt, s6_hb_r;
  logic signed [24:0] s6_ha_r;

  always_comb begin
    s6_v2_nxt = 68'(s5_q6_r) + 68'($signed({s5_v1p5_r, 17'd0}))
              + 68'($signed({p4, 35'd0}));
    s6_aa_nxt = 59'(s5_q3_r >>> 8) + 59'($signed({s5_v1p2_r, 12'd0}))
              + 59'sd140737488355328;
    s6_hb_nxt = s5_hb1_r * s5_hb2_r;
  end

  // Stage 7
  logic signed [25:0] s7_ahi;
  logic signed [21:0] s7_pd;
  logic signed [38:0] s7_hb3;
  logic signed [42:0] s7_dh_nxt, s7_dh_r;
  logic [48:0]        s7_dl_nxt, s7_dl_r;
  logic signed [68:0] s7_num_nxt, s7_num_r;
  logic signed [54:0] s7_hb4_nxt, s7_hb4_r;
  logic signed [24:0] s7_ha_r;

  always_comb begin
    s7_ahi     = 26'(s6_aa_r >>> 33);
    s7_dh_nxt  = s7_ahi * p1;
    s7_dl_nxt  = 49'(s6_aa_r[32:0]) * 49'(cal_r[CAL_T3_P1][31:16]);
    s7_pd      = 22'sd1048576 - $signed({2'b00, p_dly_r[5]});
    s7_num_nxt = 69'($signed({s7_pd, 31'd0})) - 69'(s6_v2_r);
    s7_hb3     = 39'(s6_hb_r >>> 10) + 39'sd2097152;
    s7_hb4_nxt = s7_hb3 * h2;
  end

  // Stage 8
  logic signed [42:0] s8_d_nxt, s8_d_r;
  logic [67:0]        s8_um_nxt, s8_um_r;
  logic               s8_nneg_r;
  logic signed [40:0] s8_hbf_nxt, s8_hbf_r;
  logic signed [24:0] s8_ha_r;

  always_comb begin
    s8_d_nxt   = s7_dh_r + 43'($signed({1'b0, s7_dl_r[48:33]}));
    s8_um_nxt  = s7_num_r[68] ? 68'(-s7_num_r) : 68'(s7_num_r);
    s8_hbf_nxt = 41'((56'(s7_hb4_r) + 56'sd8192) >>> 14);
  end

  // Stage 9
  logic [DEN_W-1:0]   s9_ud_nxt, s9_ud_r;
  side_t              s9_side_nxt, s9_side_r;
  logic [72:0]        s9_um25_nxt, s9_um25_r;
  logic signed [65:0] s9_hx_nxt, s9_hx_r;

  always_comb begin
    s9_ud_nxt        = s8_d_r[42] ? DEN_W'(-s8_d_r) : DEN_W'(s8_d_r);
    s9_side_nxt.neg  = s8_nneg_r ^ s8_d_r[42];
    s9_side_nxt.dz   = (s8_d_r == '0);
    s9_um25_nxt      = 73'({s8_um_r, 4'd0}) + 73'({s8_um_r, 3'd0}) + 73'(s8_um_r);
    s9_hx_nxt        = s8_ha_r * s8_hbf_r;
  end

  // Stage 10
  logic [NUM_W-1:0]   s10_n_nxt, s10_n_r;
  logic [DEN_W-1:0]   s10_ud_r;
  side_t              s10_side_r;
  logic signed [31:0] s10_hx_nxt, s10_hx_r;

  always_comb begin
    s10_n_nxt = NUM_W'({s9_um25_r, 7'd0}) - NUM_W'({s9_um25_r, 2'd0}) + NUM_W'(s9_um25_r);
    if (s9_hx_r > 66'sd2147483647) begin
      s10_hx_nxt = 32'sh7fffffff;
    end else if (s9_hx_r < -66'sd2147483648) begin
      s10_hx_nxt = 32'sh80000000;
    end else begin
      s10_hx_nxt = 32'(s9_hx_r);
    end
  end

  // Stage 11
  logic signed [16:0] s11_dq;
  logic signed [33:0] s11_dsq_nxt, s11_dsq_r;
  logic signed [31:0] s11_hx_r;

  always_comb begin
    s11_dq      = 17'(s10_hx_r >>> 15);
    s11_dsq_nxt = s11_dq * s11_dq;
  end

  // Stage 12
  logic signed [26:0] s12_t;
  logic signed [35:0] s12_c2;
  logic signed [31:0] s12_c3;
  logic signed [33:0] s12_y;
  logic [16:0]        s12_hum_nxt, s12_hum_r;

  always_comb begin
    s12_t  = 27'(s11_dsq_r >>> 7);
    s12_c2 = s12_t * h1;
    s12_c3 = 32'(s12_c2 >>> 4);
    s12_y  = 34'(s11_hx_r) - 34'(s12_c3);
    if (s12_y < 34'sd0) begin
      s12_y = '0;
    end else if (s12_y > HUM_MAX) begin
      s12_y = HUM_MAX;
    end
    s12_hum_nxt = s12_y[28:12];
  end

  always_ff @(posedge clk) begin
    s1_ta_r    <= s1_ta_nxt;
    s1_dd_r    <= s1_dd_nxt;
    s2_a_r     <= s2_a_nxt;
    s2_bm_r    <= s2_bm_nxt;
    s3_tf_r    <= s3_tf_nxt;
    s4_temp_r  <= s4_temp_nxt;
    s4_v1_r    <= s4_v1_nxt;
    s4_v1sq_r  <= s4_v1sq_nxt;
    s4_v1p2_r  <= s4_v1p2_nxt;
    s4_h5hv_r  <= s4_h5hv_nxt;
    s4_hvh6_r  <= s4_hvh6_nxt;
    s4_hvh3_r  <= s4_hvh3_nxt;
    s5_q6_r    <= s5_q6_nxt;
    s5_q3_r    <= s5_q3_nxt;
    s5_v1p5_r  <= s5_v1p5_nxt;
    s5_v1p2_r  <= s4_v1p2_r;
    s5_ha_r    <= s5_ha_nxt;
    s5_hb1_r   <= s5_hb1_nxt;
    s5_hb2_r   <= s5_hb2_nxt;
    s6_v2_r    <= s6_v2_nxt;
    s6_aa_r    <= s6_aa_nxt;
    s6_hb_r    <= s6_hb_nxt;
    s6_ha_r    <= s5_ha_r;
    s7_dh_r    <= s7_dh_nxt;
    s7_dl_r    <= s7_dl_nxt;
    s7_num_r   <= s7_num_nxt;
    s7_hb4_r   <= s7_hb4_nxt;
    s7_ha_r    <= s6_ha_r;
    s8_d_r     <= s8_d_nxt;
    s8_um_r    <= s8_um_nxt;
    s8_nneg_r  <= s7_num_r[68];
    s8_hbf_r   <= s8_hbf_nxt;
    s8_ha_r    <= s7_ha_r;
    s9_ud_r    <= s9_ud_nxt;
    s9_side_r  <= s9_side_nxt;
    s9_um25_r  <= s9_um25_nxt;
    s9_hx_r    <= s9_hx_nxt;
    s10_n_r    <= s10_n_nxt;
    s10_ud_r   <= s9_ud_r;
    s10_side_r <= s9_side_r;
    s10_hx_r   <= s10_hx_nxt;
    s11_dsq_r  <= s11_dsq_nxt;
    s11_hx_r   <= s10_hx_r;
    s12_hum_r  <= s12_hum_nxt;
  end

  logic [QUO_W-1:0] quo;

  hptc_div u_div (
    .clk (clk),
    .num (s10_n_r),
    .den (s10_ud_r),
    .quo (quo)
  );

  logic signed [14:0] temp_dly_r [0:TEMP_DLY-1];
  logic [16:0]        hum_dly_r  [0:HUM_DLY-1];
  side_t              side_dly_r [0:SIDE_DLY-1];

  always_ff @(posedge clk) begin
    temp_dly_r[0] <= s4_temp_r;
    for (int i = 1; i < TEMP_DLY; i++) begin
      temp_dly_r[i] <= temp_dly_r[i-1];
    end
    hum_dly_r[0] <= s12_hum_r;
    for (int i = 1; i < HUM_DLY; i++) begin
      hum_dly_r[i] <= hum_dly_r[i-1];
    end
    side_dly_r[0] <= s10_side_r;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  // Final pressure polynomial.
  logic signed [36:0] pa_p_nxt, pa_p_r, pb_p_r;
  logic signed [23:0] pa_a13;
  logic signed [47:0] pa_asq_nxt, pa_asq_r;
  logic signed [52:0] pa_p8p_nxt, pa_p8p_r;
  logic signed [63:0] pb_v1_nxt, pb_v1_r;
  logic signed [33:0] pb_v2_nxt, pb_v2_r;
  logic signed [39:0] pc_sum;
  logic signed [32:0] pc_pr;
  logic [24:0]        pc_press_nxt;

  always_comb begin
    pa_p_nxt   = side_dly_r[DIV_LAT-1].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    pa_a13     = 24'(pa_p_nxt >>> 13);
    pa_asq_nxt = pa_a13 * pa_a13;
    pa_p8p_nxt = pa_p_nxt * p8;
    pb_v1_nxt  = pa_asq_r * p9;
    pb_v2_nxt  = 34'(pa_p8p_r >>> 19);
    pc_sum     = 40'(pb_p_r) + 40'(pb_v1_r >>> 25) + 40'(pb_v2_r);
    pc_pr      = 33'(pc_sum >>> 8) + 33'($signed({p7, 4'd0}));
    if (side_dly_r[SIDE_DLY-1].dz || pc_pr < 33'sd0) begin
      pc_press_nxt = '0;
    end else if (pc_pr > PRESS_MAX) begin
      pc_press_nxt = 25'(PRESS_MAX);
    end else begin
      pc_press_nxt = 25'(pc_pr);
    end
  end

  always_ff @(posedge clk) begin
    pa_p_r            <= pa_p_nxt;
    pa_asq_r          <= pa_asq_nxt;
    pa_p8p_r          <= pa_p8p_nxt;
    pb_p_r            <= pa_p_r;
    pb_v1_r           <= pb_v1_nxt;
    pb_v2_r           <= pb_v2_nxt;
    out_temp_centi    <= temp_dly_r[TEMP_DLY-1];
    out_humid_q10     <= hum_dly_r[HUM_DLY-1];
    out_press_q8      <= pc_press_nxt;
    out_press_invalid <= side_dly_r[SIDE_DLY-1].dz;
  end

  assign out_valid = out_valid_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result strobe missing after a transaction");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_press_invalid) |-> (out_press_q8 == '0))
    else $error("invalid pressure is not zero");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humid_q10 <= 17'd102400))
    else $error("humidity above full scale");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centi >= -15'sd4000 && out_temp_centi <= 15'sd8500))
    else $error("temperature outside saturation range");

endmodule
